### design/u8c_pkg.sv
package u8c_pkg;

    // Extra rule applied to the byte after a lead
    typedef enum logic [2:0] {
        RULE_NONE = 3'd0,
        RULE_E0   = 3'd1,
        RULE_ED   = 3'd2,
        RULE_F0   = 3'd3,
        RULE_F4   = 3'd4
    } t_rule;

    // Result classes
    typedef enum logic [1:0] {
        CLASS_LEGACY = 2'd0,
        CLASS_BOM    = 2'd1,
        CLASS_ASCII  = 2'd2,
        CLASS_UTF8   = 2'd3
    } t_class;

    // Scan state carried from byte to byte
    typedef struct packed {
        logic [1:0] prefix_count;
        logic       bom_matching;
        logic [1:0] continuations_left;
        t_rule      second_byte_rule;
        logic       invalid_seen;
        logic       only_ascii;
    } t_state;

    localparam t_state STATE_RESET = '{
        prefix_count:       2'd0,
        bom_matching:       1'b1,
        continuations_left: 2'd0,
        second_byte_rule:   RULE_NONE,
        invalid_seen:       1'b0,
        only_ascii:         1'b1
    };

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;

    // Byte order mark byte expected at a given prefix position
    function automatic logic [7:0] bom_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = BOM_BYTE0;
            2'd1:    b = BOM_BYTE1;
            default: b = BOM_BYTE2;
        endcase
        return b;
    endfunction

endpackage

### design/u8c_step.sv
module u8c_step
    import u8c_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output t_state     o_state_next,
    output t_class     o_class
);

    t_state w_upd;
    logic   w_bad;

    always_comb begin
        w_upd = i_state;
        w_bad = 1'b0;

        // Compare the leading bytes with the byte order mark
        if (i_state.prefix_count != 2'd3) begin
            if (i_byte_value != bom_byte(i_state.prefix_count)) begin
                w_upd.bom_matching = 1'b0;
            end
            w_upd.prefix_count = i_state.prefix_count + 2'd1;
        end

        if (i_state.continuations_left != 2'd0) begin
            // Check a continuation byte and its second-byte rule
            w_bad = (i_byte_value[7:6] != 2'b10);
            unique case (i_state.second_byte_rule)
                RULE_E0: if (i_byte_value[7:5] == 3'b100) w_bad = 1'b1;
                RULE_ED: if (i_byte_value[7:5] == 3'b101) w_bad = 1'b1;
                RULE_F0: if (i_byte_value[7:4] == 4'h8)   w_bad = 1'b1;
                RULE_F4: if (i_byte_value > 8'h8F)        w_bad = 1'b1;
                default: ;
            endcase
            if (w_bad) begin
                w_upd.invalid_seen = 1'b1;
            end
            w_upd.second_byte_rule   = RULE_NONE;
            w_upd.continuations_left = i_state.continuations_left - 2'd1;
        end else if (i_byte_value[7]) begin
            // Decode a lead byte
            w_upd.only_ascii = 1'b0;
            priority if (i_byte_value[7:5] == 3'b110) begin
                if (i_byte_value[7:1] == 7'h60) begin
                    w_upd.invalid_seen = 1'b1;
                end
                w_upd.continuations_left = 2'd1;
                w_upd.second_byte_rule   = RULE_NONE;
            end else if (i_byte_value[7:4] == 4'hE) begin
                w_upd.continuations_left = 2'd2;
                w_upd.second_byte_rule   = (i_byte_value == 8'hE0) ? RULE_E0 :
                                           (i_byte_value == 8'hED) ? RULE_ED : RULE_NONE;
            end else if (i_byte_value[7:3] == 5'b11110) begin
                if (i_byte_value > 8'hF4) begin
                    w_upd.invalid_seen = 1'b1;
                end
                w_upd.continuations_left = 2'd3;
                w_upd.second_byte_rule   = (i_byte_value == 8'hF0) ? RULE_F0 :
                                           (i_byte_value == 8'hF4) ? RULE_F4 : RULE_NONE;
            end else begin
                w_upd.invalid_seen = 1'b1;
            end
        end

        // Classify from the updated state
        priority if (w_upd.prefix_count == 2'd3 && w_upd.bom_matching) begin
            o_class = CLASS_BOM;
        end else if (w_upd.invalid_seen || w_upd.continuations_left != 2'd0) begin
            o_class = CLASS_LEGACY;
        end else if (w_upd.only_ascii) begin
            o_class = CLASS_ASCII;
        end else begin
            o_class = CLASS_UTF8;
        end

        // Return to reset after the final byte
        o_state_next = i_last_byte ? STATE_RESET : w_upd;
    end

endmodule

### design/utf8_text_encoding_classifier.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid / o_in_stall | i_byte_value[7:0], i_last_byte
// out     | output    | o_out_valid / i_out_stall | o_encoding_class[1:0]
//
// One byte per cycle while no final byte waits on a stalled result; each byte
// is held in the input register, where the scan logic updates the state, and
// a final byte then lands its class in the result register.
// Reset (synchronous, active low) empties both registers and restores the scan state.
// Only a final byte waits on a stalled result; other bytes keep flowing.
module utf8_text_encoding_classifier
    import u8c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_encoding_class
);

    logic       r_in_valid;
    logic [7:0] r_byte_value;
    logic       r_last_byte;
    t_state     r_state;
    logic       r_out_valid;
    t_class     r_out_class;

    t_state     n_state;
    t_class     w_class;
    logic       w_out_busy;
    logic       w_advance;
    logic       w_in_take;

    u8c_step u_step (
        .i_state      (r_state),
        .i_byte_value (r_byte_value),
        .i_last_byte  (r_last_byte),
        .o_state_next (n_state),
        .o_class      (w_class)
    );

    // A final byte may leave only when the result register frees up
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_advance  = r_in_valid && !(r_last_byte && w_out_busy);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_byte_value <= i_byte_value;
            r_last_byte  <= i_last_byte;
        end
    end

    // Advance the scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && r_last_byte) begin
            r_out_class <= w_class;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_encoding_class = r_out_class;

    // A final byte restores the scan state
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_last_byte |=> r_state == STATE_RESET)
        else $error("scan state not restored after final byte");

    // Only a final byte blocked by a stalled result stalls the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_last_byte && r_out_valid && i_out_stall)
        else $error("input stalled without a pending final byte");

    // An all-ASCII scan never expects continuations
    a_ascii_no_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.only_ascii |-> r_state.continuations_left == 2'd0
                               && r_state.second_byte_rule == RULE_NONE)
        else $error("ascii state with pending continuation");

endmodule
